// File: hdl/gsm_pkg.sv
// Shared constants and types of the glob segment matcher.
package gsm_pkg;

	// Pattern capacity and character width.
	localparam int PATTERN_CHARS = 32;
	localparam int CHAR_BITS     = 8;
	localparam int TEXT_BITS     = 8;
	localparam int LEN_BITS      = 6;

	// Pattern character registers: four 64-bit words, lowest character first.
	localparam int CHAR_REGS     = 4;
	localparam int REG_BITS      = 64;
	localparam int PAT_REG_BITS  = CHAR_REGS * REG_BITS;

	// Width used to compare the length register against cell positions.
	localparam int POS_BITS      = 7;

	// Configuration bus.
	localparam int ADDR_BITS     = 6;
	localparam int IDX_BITS      = 3;

	// Register indexes.
	localparam logic [IDX_BITS-1:0] REG_LEN    = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_CHARS0 = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_CHARS1 = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_CHARS2 = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_CHARS3 = 3'd4;

	// Wildcard characters.
	localparam logic [CHAR_BITS-1:0] STAR_CHAR     = CHAR_BITS'(8'h2A);
	localparam logic [CHAR_BITS-1:0] QUESTION_CHAR = CHAR_BITS'(8'h3F);

	// Control that every cell sees in the same cycle.
	typedef struct packed {
		logic restart;  // state is implicitly the start set
		logic has_char; // current request carries a character
		logic load;     // accepted character that does not end the name
	} gsm_ctl_t;

	// Signals passed from one cell to the next.
	typedef struct packed {
		logic start;    // start-set bit reaching the next position
		logic nxt;      // next-set bit reaching the next position
	} gsm_link_t;

endpackage

// File: hdl/glob_segment_matcher.sv
// Top level of the glob segment matcher: register file, cell chain and result register.
//
//   channel  | direction | signals                              | content
//   ---------+-----------+--------------------------------------+---------------------------
//   s_       | in        | tvalid tready tdata tuser tlast      | tdata[7:0] text_char,
//            |           |                                      | tuser has_char, tlast end
//   m_       | out       | tvalid tready tdata                  | tdata[0] matched
//   apb      | in/out    | psel penable pwrite paddr pwdata ... | registers at 8*index
//
// One character is taken every cycle; the result of a name appears in the cycle
// after its last request and waits in a single output register.
// The cell chain updates all pattern positions in the same cycle, so the position
// set never stalls the input; only a full output register that is not taken does.
// Reset loads the start set; any write to a defined register restarts the name in progress.
module glob_segment_matcher import gsm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // [7:0] text_char
	input  logic                  s_tuser,  // [0] has_char
	input  logic                  s_tlast,
	// Result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,  // [0] matched, [7:1] zero
	// Configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_BITS-1:0]  paddr,
	input  logic [REG_BITS-1:0]   pwdata,
	output logic [REG_BITS-1:0]   prdata,
	output logic                  pready
);

	logic [LEN_BITS-1:0]     pattern_len;
	logic [PAT_REG_BITS-1:0] pattern_bits;
	logic                    cfg_wr;
	logic                    restart_q;
	logic                    end_q;
	logic                    m_tvalid_q;
	logic                    matched_q;
	logic                    in_acc;
	gsm_ctl_t                ctl;
	gsm_link_t               link [PATTERN_CHARS+1];
	logic [PATTERN_CHARS:0]  pos_bits;
	logic [PATTERN_CHARS:0]  at_end;
	logic [POS_BITS-1:0]     len_ext;
	logic                    end_eff;
	logic                    match;

	gsm_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.pattern_len  (pattern_len),
		.pattern_bits (pattern_bits),
		.cfg_wr       (cfg_wr)
	);

	// Handshake: a request is taken whenever the result register is free or draining.
	assign s_tready = ~m_tvalid_q | m_tready;
	assign in_acc   = s_tvalid & s_tready;

	assign ctl.restart  = restart_q;
	assign ctl.has_char = s_tuser;
	assign ctl.load     = in_acc & s_tuser & ~s_tlast;

	assign len_ext = POS_BITS'(pattern_len);

	// Chain entry: position zero is always in the start set.
	assign link[0].start = 1'b1;
	assign link[0].nxt   = 1'b0;

	// Row of cells, one per pattern position.
	for (genvar i = 0; i < PATTERN_CHARS; i++) begin : g_cell
		logic [CHAR_BITS-1:0] pat_char;
		logic                 active;

		// Characters past the register bits read as zero.
		for (genvar b = 0; b < CHAR_BITS; b++) begin : g_bit
			if (i * CHAR_BITS + b < PAT_REG_BITS) begin : g_in
				assign pat_char[b] = pattern_bits[i*CHAR_BITS+b];
			end else begin : g_out
				assign pat_char[b] = 1'b0;
			end
		end

		assign active    = (len_ext > POS_BITS'(i));
		assign at_end[i] = (len_ext == POS_BITS'(i));

		gsm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.pat_char  (pat_char),
			.active    (active),
			.text_char (s_tdata[TEXT_BITS-1:0]),
			.link_in   (link[i]),
			.link_out  (link[i+1]),
			.pos_bit   (pos_bits[i])
		);
	end

	// Final position past the last pattern character.
	assign at_end[PATTERN_CHARS]   = (len_ext >= POS_BITS'(PATTERN_CHARS));
	assign end_eff                 = restart_q ? link[PATTERN_CHARS].start : end_q;
	assign pos_bits[PATTERN_CHARS] = s_tuser ? link[PATTERN_CHARS].nxt : end_eff;

	// The name matches when the pattern-end position is reachable.
	assign match = |(pos_bits & at_end);

	// Position-set control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q <= 1'b1;
			end_q     <= 1'b0;
		end else begin
			if (ctl.load) begin
				end_q <= link[PATTERN_CHARS].nxt;
			end
			if (cfg_wr || (in_acc && s_tlast)) begin
				restart_q <= 1'b1;
			end else if (ctl.load) begin
				restart_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (in_acc && s_tlast) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && s_tlast) begin
			matched_q <= match;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, matched_q};

endmodule

// File: hdl/gsm_cfg.sv
// APB register file holding the pattern length and the pattern characters.
module gsm_cfg import gsm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_BITS-1:0]      paddr,
	input  logic [REG_BITS-1:0]       pwdata,
	output logic [REG_BITS-1:0]       prdata,
	output logic                      pready,
	output logic [LEN_BITS-1:0]       pattern_len,
	output logic [PAT_REG_BITS-1:0]   pattern_bits,
	output logic                      cfg_wr
);

	logic [LEN_BITS-1:0] len_q;
	logic [REG_BITS-1:0] chars_q [CHAR_REGS];
	logic [IDX_BITS-1:0] idx;
	logic                wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_BITS-1:ADDR_BITS-IDX_BITS];
	assign wr_en  = psel & penable & pwrite;

	// A write to a defined register restarts the name in progress.
	always_comb begin
		unique case (idx)
			REG_LEN, REG_CHARS0, REG_CHARS1, REG_CHARS2, REG_CHARS3: cfg_wr = wr_en;
			default: cfg_wr = 1'b0;
		endcase
	end

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			for (int r = 0; r < CHAR_REGS; r++) begin
				chars_q[r] <= '0;
			end
		end else if (wr_en) begin
			unique case (idx)
				REG_LEN:    len_q      <= pwdata[LEN_BITS-1:0];
				REG_CHARS0: chars_q[0] <= pwdata;
				REG_CHARS1: chars_q[1] <= pwdata;
				REG_CHARS2: chars_q[2] <= pwdata;
				REG_CHARS3: chars_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		unique case (idx)
			REG_LEN:    prdata = REG_BITS'(len_q);
			REG_CHARS0: prdata = chars_q[0];
			REG_CHARS1: prdata = chars_q[1];
			REG_CHARS2: prdata = chars_q[2];
			REG_CHARS3: prdata = chars_q[3];
			default:    prdata = '0;
		endcase
	end

	// Flatten the character words into one bit string.
	always_comb begin
		for (int r = 0; r < CHAR_REGS; r++) begin
			pattern_bits[r*REG_BITS +: REG_BITS] = chars_q[r];
		end
	end

	assign pattern_len = len_q;

endmodule

// File: hdl/gsm_cell.sv
// One pattern position: holds its reachable bit and advances it by one character.
module gsm_cell import gsm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gsm_ctl_t             ctl,
	input  logic [CHAR_BITS-1:0] pat_char,
	input  logic                 active,
	input  logic [TEXT_BITS-1:0] text_char,
	input  gsm_link_t            link_in,
	output gsm_link_t            link_out,
	output logic                 pos_bit
);

	logic r_q;
	logic is_star;
	logic star_act;
	logic hit;
	logic r_eff;
	logic stay;
	logic adv;
	logic next_bit;

	// Character classification for this position.
	assign is_star  = (pat_char == STAR_CHAR);
	assign star_act = active & is_star;
	assign hit      = (pat_char == QUESTION_CHAR) | (pat_char == CHAR_BITS'(text_char));

	// The start set ripples through stars from position zero.
	assign link_out.start = link_in.start & star_act;
	assign r_eff          = ctl.restart ? link_in.start : r_q;

	// A star keeps its position; a matching character moves one position on.
	assign stay     = active & r_eff & is_star;
	assign adv      = active & r_eff & ~is_star & hit;
	assign next_bit = stay | link_in.nxt;

	// Pass the advance and the star closure to the neighbor.
	assign link_out.nxt = adv | (next_bit & star_act);

	assign pos_bit = ctl.has_char ? next_bit : r_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= 1'b0;
		end else if (ctl.load) begin
			r_q <= next_bit;
		end
	end

endmodule

// File: verif/testbench.sv
// Self-checking testbench of the glob segment matcher: directed plan, random names, flow control.
`timescale 1ns / 1ps

module testbench;
	import gsm_pkg::*;

	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 3;
	localparam int ITEM_TARGET   = 1050;
	localparam int PHASE_ITEMS   = 25;
	localparam int NAME_CAP      = 48;
	localparam int PLAN_ROWS     = 30;

	localparam logic [7:0]          LETTER_A  = "a";
	localparam logic [REG_BITS-1:0] STAR_WORD = {8{STAR_CHAR}};
	localparam logic [REG_BITS-1:0] ONES_WORD = '1;
	localparam logic [PATTERN_CHARS:0] START_POS = {{PATTERN_CHARS{1'b0}}, 1'b1};

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;
	typedef enum int {FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH} flow_t;
	typedef enum int {MUT_REPLACE, MUT_DROP, MUT_INSERT} mutate_t;
	typedef enum int {PAT_RANDOM, PAT_ALL_ONES, PAT_CLEARED} pattern_style_t;

	// One step of the directed plan: a register write or a request.
	typedef struct {
		row_kind_t            kind;
		logic [IDX_BITS-1:0]  idx;
		logic [REG_BITS-1:0]  value;
		logic [7:0]           ch;
		logic                 has;
		logic                 last;
		logic                 fixed;  // result typed in below
		logic                 want;
	} plan_row_t;

	// Fixed results are only given where they are obvious; the rest come from the predictor.
	plan_row_t plan [0:PLAN_ROWS-1] = '{
		'{ROW_ITEM,  REG_LEN,    '0,                     8'h00, 1'b0, 1'b1, 1'b1, 1'b1},
		'{ROW_ITEM,  REG_LEN,    '0,                     "a",   1'b1, 1'b1, 1'b1, 1'b0},
		'{ROW_ITEM,  REG_LEN,    '0,                     8'h5A, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM,  REG_LEN,    '0,                     8'hA5, 1'b0, 1'b1, 1'b1, 1'b1},
		'{ROW_WRITE, REG_CHARS0, 64'h0000_0000_623F_2A61, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_WRITE, REG_LEN,    64'd4,                  8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM,  REG_LEN,    '0,                     "a",   1'b1, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM,  REG_LEN,    '0,                     "x",   1'b1, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM,  REG_LEN,    '0,                     "b",   1'b1, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM,  REG_LEN,    '0,                     "a",   1'b1, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM,  REG_LEN,    '0,                     "b",   1'b1, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM,  REG_LEN,    '0,                     8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM,  REG_LEN,    '0,                     "a",   1'b1, 1'b0, 1'b0, 1'b0},
		'{ROW_WRITE, REG_LEN,    64'd63,                 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_WRITE, REG_CHARS1, STAR_WORD,              8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_WRITE, REG_CHARS2, STAR_WORD,              8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_WRITE, REG_CHARS3, STAR_WORD,              8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_WRITE, REG_CHARS0, 64'h2A2A_2A2A_623F_2A61, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM,  REG_LEN,    '0,                     "a",   1'b1, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM,  REG_LEN,    '0,                     8'h00, 1'b1, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM,  REG_LEN,    '0,                     8'hFF, 1'b1, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM,  REG_LEN,    '0,                     "b",   1'b1, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM,  REG_LEN,    '0,                     8'h00, 1'b1, 1'b1, 1'b1, 1'b0},
		'{ROW_WRITE, REG_CHARS0, ONES_WORD,              8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_WRITE, REG_CHARS1, ONES_WORD,              8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_WRITE, REG_CHARS2, ONES_WORD,              8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_WRITE, REG_CHARS3, ONES_WORD,              8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM,  REG_LEN,    '0,                     8'hFF, 1'b1, 1'b1, 1'b0, 1'b0},
		'{ROW_WRITE, REG_LEN,    64'd0,                  8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM,  REG_LEN,    '0,                     8'h00, 1'b0, 1'b1, 1'b1, 1'b1}
	};

	// Block ports; the inputs driven here are known from time zero.
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;   // [7:0] text_char
	logic                 s_tuser = 1'b0; // [0] has_char
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [7:0]           m_tdata;        // [0] matched, [7:1] zero
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [REG_BITS-1:0]  pwdata = '0;
	logic [REG_BITS-1:0]  prdata;
	logic                 pready;

	// Predictor state: pattern registers and the reachable position set.
	logic [LEN_BITS-1:0]   pat_len;
	logic [REG_BITS-1:0]   pat_word [CHAR_REGS];
	logic [CHAR_BITS-1:0]  pat_char [PATTERN_CHARS];
	logic [PATTERN_CHARS:0] live_set;
	logic                  pending_matches [$];

	// Stimulus state and run statistics.
	logic [LEN_BITS-1:0]  next_len;
	logic [REG_BITS-1:0]  next_word [CHAR_REGS];
	logic [7:0]           name_q [$];
	logic                 match_due;
	int                   src_idle_pct = 0;
	int                   sink_stall_pct = 0;
	int                   items_sent = 0;
	int                   names_sent = 0;
	int                   matches_seen = 0;
	int                   writes_done = 0;
	int                   errors = 0;
	int                   stuck_cycles = 0;
	int                   phase = 0;
	int                   phase_start;

	glob_segment_matcher uut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Pattern length as the block sees it.
	function automatic int eff_len();
		return (int'(pat_len) > PATTERN_CHARS) ? PATTERN_CHARS : int'(pat_len);
	endfunction

	// Add every position that a star lets the set skip to.
	function automatic logic [PATTERN_CHARS:0] star_closure(input logic [PATTERN_CHARS:0] set_in);
		logic [PATTERN_CHARS:0] s;
		s = set_in;
		for (int i = 0; i < eff_len(); i++)
			if (s[i] && pat_char[i] == STAR_CHAR) s[i + 1] = 1'b1;
		return s;
	endfunction

	// Register write: update the pattern and restart at the start set.
	function automatic void store_register(input logic [IDX_BITS-1:0] idx,
			input logic [REG_BITS-1:0] value);
		logic [PAT_REG_BITS-1:0] flat;
		case (idx)
			REG_LEN:    pat_len = value[LEN_BITS-1:0];
			REG_CHARS0: pat_word[0] = value;
			REG_CHARS1: pat_word[1] = value;
			REG_CHARS2: pat_word[2] = value;
			REG_CHARS3: pat_word[3] = value;
			default:    return;
		endcase
		flat = {pat_word[3], pat_word[2], pat_word[1], pat_word[0]};
		for (int i = 0; i < PATTERN_CHARS; i++)
			pat_char[i] = flat[i * CHAR_BITS +: CHAR_BITS];
		live_set = star_closure(START_POS);
	endfunction

	// Move the position set by one accepted request; a name end queues its match flag.
	function automatic void advance_positions(input logic [7:0] ch, input logic has,
			input logic last, input logic fixed, input logic want);
		logic [PATTERN_CHARS:0] nxt;
		int len;
		len = eff_len();
		if (has) begin
			nxt = '0;
			for (int i = 0; i < len; i++) begin
				if (live_set[i]) begin
					if (pat_char[i] == STAR_CHAR)
						nxt[i] = 1'b1;
					else if (pat_char[i] == QUESTION_CHAR || pat_char[i] == CHAR_BITS'(ch))
						nxt[i + 1] = 1'b1;
				end
			end
			live_set = star_closure(nxt);
		end
		if (last) begin
			pending_matches = {pending_matches, (fixed ? want : live_set[len])};
			live_set = star_closure(START_POS);
		end
	endfunction

	function automatic logic [7:0] pick_name_char();
		if ($urandom_range(99) < 80)
			return LETTER_A + 8'($urandom_range(2));
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] pick_pattern_char();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return LETTER_A + 8'($urandom_range(2));
		if (r < 65)
			return STAR_CHAR;
		if (r < 85)
			return QUESTION_CHAR;
		return 8'($urandom_range(255));
	endfunction

	// Present one request, with random sender gaps, and wait until it is taken.
	task automatic offer_request(input logic [7:0] ch, input logic has, input logic last,
			input logic fixed, input logic want);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tuser <= has;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		advance_positions(ch, has, last, fixed, want);
		items_sent++;
		if (last) names_sent++;
	endtask

	// Hold the sender until every queued result has come, then let the block settle.
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup and access cycle; the register takes the value at the access edge.
	task automatic write_register(input logic [IDX_BITS-1:0] idx,
			input logic [REG_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BITS'({idx, 3'b000});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		store_register(idx, value);
		writes_done++;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Choose the next pattern: all ones, cleared, or random with mostly short ones, a few long or past capacity.
	task automatic roll_pattern(input pattern_style_t style);
		int r;
		case (style)
			PAT_ALL_ONES: begin
				next_len = '1;
				foreach (next_word[w]) next_word[w] = ONES_WORD;
			end
			PAT_CLEARED: begin
				next_len = '0;
				foreach (next_word[w]) next_word[w] = '0;
			end
			default: begin
				r = $urandom_range(99);
				if (r < 70)
					next_len = LEN_BITS'($urandom_range(8));
				else if (r < 90)
					next_len = LEN_BITS'($urandom_range(32, 9));
				else
					next_len = LEN_BITS'($urandom_range(63, 33));
				for (int i = 0; i < PATTERN_CHARS; i++)
					next_word[i / 8][(i % 8) * 8 +: 8] = pick_pattern_char();
			end
		endcase
	endtask

	// Build a name that fits the current pattern, sometimes broken or fully random.
	task automatic build_name();
		int pos;
		name_q.delete();
		if ($urandom_range(99) < 10) begin
			repeat ($urandom_range(6)) name_q = {name_q, pick_name_char()};
			return;
		end
		for (int i = 0; i < eff_len(); i++) begin
			if (pat_char[i] == STAR_CHAR)
				repeat ($urandom_range(3)) name_q = {name_q, pick_name_char()};
			else if (pat_char[i] == QUESTION_CHAR)
				name_q = {name_q, pick_name_char()};
			else
				name_q = {name_q, pat_char[i]};
		end
		if ($urandom_range(99) < 30) begin
			pos = (name_q.size() == 0) ? 0 : $urandom_range(name_q.size() - 1);
			case (mutate_t'($urandom_range(2)))
				MUT_REPLACE: if (name_q.size() != 0) name_q[pos] = pick_name_char();
				MUT_DROP:    if (name_q.size() != 0) name_q.delete(pos);
				default:     name_q.insert(pos, pick_name_char());
			endcase
		end
		while (name_q.size() > NAME_CAP) void'(name_q.pop_back());
	endtask

	// Stream the name, with an occasional request that carries nothing.
	task automatic send_name();
		if (name_q.size() == 0) begin
			offer_request(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, 1'b0);
			return;
		end
		foreach (name_q[i]) begin
			if ($urandom_range(99) < 8)
				offer_request(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, 1'b0);
			offer_request(name_q[i], 1'b1, i == name_q.size() - 1, 1'b0, 1'b0);
		end
	endtask

	task automatic set_flow(input flow_t mode);
		case (mode)
			FLOW_FREE: begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
			end
			FLOW_SENDER_IDLE: begin
				src_idle_pct = 86;
				sink_stall_pct = 0;
			end
			FLOW_RECEIVER_STALL: begin
				src_idle_pct = 0;
				sink_stall_pct = 86;
			end
			default: begin
				src_idle_pct = 25;
				sink_stall_pct = 25;
			end
		endcase
	endtask

	// Result side: random stalls and comparison with the oldest expected flag.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
		if (m_tvalid && m_tready) begin
			if (m_tdata[0] === 1'b1) matches_seen++;
			if (pending_matches.size() == 0) begin
				errors++;
				$display("%0t: result 0x%02h arrived with no name pending", $time, m_tdata);
			end else begin
				match_due = pending_matches.pop_front();
				if (m_tdata !== {7'b0, match_due}) begin
					errors++;
					$display("%0t: match flag expected %0d, got tdata 0x%02h",
						$time, match_due, m_tdata);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		foreach (pat_word[w]) pat_word[w] = '0;
		store_register(REG_LEN, '0);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan.
		foreach (plan[r]) begin
			if (plan[r].kind == ROW_WRITE) begin
				wait_results_drained();
				write_register(plan[r].idx, plan[r].value);
			end else begin
				offer_request(plan[r].ch, plan[r].has, plan[r].last, plan[r].fixed, plan[r].want);
			end
		end

		// Random phases: new pattern, then names under one flow mode.
		while (items_sent < ITEM_TARGET) begin
			wait_results_drained();
			set_flow(flow_t'(phase % 4));
			roll_pattern(phase == 0 ? PAT_ALL_ONES : (phase == 1 ? PAT_CLEARED : PAT_RANDOM));
			write_register(REG_CHARS0, next_word[0]);
			write_register(REG_CHARS1, next_word[1]);
			write_register(REG_CHARS2, next_word[2]);
			write_register(REG_CHARS3, next_word[3]);
			write_register(REG_LEN, 64'(next_len));
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				build_name();
				send_name();
				if ($urandom_range(19) == 0) wait_results_drained();
			end
			// Leave a name unfinished so that the next write drops it.
			if ($urandom_range(99) < 30)
				repeat ($urandom_range(3, 1)) offer_request(pick_name_char(), 1'b1, 1'b0, 1'b0, 1'b0);
			phase++;
		end
		wait_results_drained();
		if (pending_matches.size() != 0) begin
			errors++;
			$display("%0t: %0d match flags never arrived", $time, pending_matches.size());
		end

		$display("Streamed %0d items in %0d names, %0d of them matching, under %0d patterns.",
			items_sent, names_sent, matches_seen, phase);
		$display("Register writes: %0d; flow modes free, sender idle, receiver stall and both.",
			writes_done);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
